### hdl/lstm_peephole_cell_update_macros.svh
// Assertion macros for the LSTM peephole cell update block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef LSTM_PEEPHOLE_CELL_UPDATE_MACROS_SVH
`define LSTM_PEEPHOLE_CELL_UPDATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define LPCU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcu assertion failed");
// Next-cycle implication.
`define LPCU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcu assertion failed");
`else
`define LPCU_ASSERT_IMP(lbl, ante, cons)
`define LPCU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/lpcu_pkg.sv
package lpcu_pkg;

    // Data word and activation widths.
    localparam int DATA_W = 16;
    localparam int ACT_W  = 17;

    // Table entry widths.
    localparam int BIAS_W = 4 * DATA_W;
    localparam int PEEP_W = 3 * DATA_W;

    // Number of register stages from acceptance to the output register.
    localparam int PIPE_DEPTH = 11;

    // Request function codes.
    localparam logic FUNC_COMPUTE = 1'b0;
    localparam logic FUNC_LOAD    = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACT_W-1:0]  act_t;

endpackage

### hdl/lpcu_ram.sv
module lpcu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lstm_peephole_cell_update.sv
// A compute request's result is registered through stages s1 to s11 and shown at the output registers.
// Throughput: one request per cycle; a stall at the output holds the whole pipeline.
// Load requests write the weight tables at acceptance and produce no result.
// Reset clears all pipeline valid bits; the weight tables are not cleared.
module lstm_peephole_cell_update #(
    parameter int UNITS     = 256,
    parameter int FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  unit,
    input  logic signed [15:0] gate_x_0,
    input  logic signed [15:0] gate_x_1,
    input  logic signed [15:0] gate_x_2,
    input  logic signed [15:0] gate_x_3,
    input  logic signed [15:0] gate_h_0,
    input  logic signed [15:0] gate_h_1,
    input  logic signed [15:0] gate_h_2,
    input  logic signed [15:0] gate_h_3,
    input  logic signed [15:0] cell_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] cell_out,
    output logic signed [15:0] hidden_out
);

    localparam int IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int RED_W = (IDX_W > 8) ? IDX_W : 8;
    localparam int NS    = lpcu_pkg::PIPE_DEPTH;

    // Activation constants in fixed point with FRAC_BITS fraction bits.
    localparam logic [18:0] ONE_U   = 19'(1) << FRAC_BITS;
    localparam logic [18:0] TH_SAT  = 19'(5) << FRAC_BITS;
    localparam logic [18:0] TH_MID  = 19'(19) << (FRAC_BITS - 3);
    localparam logic [18:0] OFF_MID = 19'(27) << (FRAC_BITS - 5);
    localparam logic [18:0] OFF_LO  = 19'(5) << (FRAC_BITS - 3);
    localparam logic signed [18:0] ONE_S = 19'sd1 <<< FRAC_BITS;
    localparam logic signed [39:0] HALF  = 40'sd1 <<< (FRAC_BITS - 1);

    // Round to nearest, ties up, dropping the fraction bits.
    function automatic logic signed [39:0] rnd(input logic signed [39:0] v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    // Saturate to a 16-bit word.
    function automatic lpcu_pkg::data_t sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
        begin
            return 16'sh7fff;
        end
        else if (v < -40'sd32768)
        begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Piecewise linear sigmoid.
    function automatic lpcu_pkg::act_t sigm(input logic signed [17:0] x);
        logic [17:0] a;
        logic [18:0] av;
        logic [18:0] y;
        a  = x[17] ? 18'(-x) : 18'(x);
        av = 19'(a);
        if (av >= TH_SAT)
        begin
            y = ONE_U;
        end
        else if (av >= TH_MID)
        begin
            y = (av >> 5) + OFF_MID;
        end
        else if (av >= ONE_U)
        begin
            y = (av >> 3) + OFF_LO;
        end
        else
        begin
            y = (av >> 2) + (ONE_U >> 1);
        end
        return x[17] ? 17'(ONE_U - y) : 17'(y);
    endfunction

    // tanh(x) = 2 * sigmoid(2x) - 1.
    function automatic lpcu_pkg::act_t tanh_fx(input lpcu_pkg::act_t x);
        logic signed [18:0] s;
        s = 19'(sigm({x, 1'b0}));
        return 17'(s + s - ONE_S);
    endfunction

    // Unit index modulo the table depth by restoring subtraction.
    function automatic logic [7:0] unit_mod(input logic [7:0] u);
        logic [19:0] r;
        r = 20'(u);
        for (int s = 7; s >= 0; s--)
        begin
            if (r >= (20'(UNITS) << s))
            begin
                r = r - (20'(UNITS) << s);
            end
        end
        return r[7:0];
    endfunction

    logic               adv;
    logic               in_acc;
    logic               cmp_acc;
    logic               load_acc;
    logic [RED_W-1:0]   idx_ext;
    logic [IDX_W-1:0]   idx;
    logic [lpcu_pkg::BIAS_W-1:0] bias_rd;
    logic [lpcu_pkg::PEEP_W-1:0] peep_rd;
    logic [NS-1:0]      vld_reg;

    // Stage registers.
    lpcu_pkg::data_t    s1_x_reg [4];
    lpcu_pkg::data_t    s1_h_reg [4];
    lpcu_pkg::data_t    s1_c_reg;
    logic signed [17:0] s2_sum_reg [4];
    logic signed [31:0] s2_pi_reg;
    logic signed [31:0] s2_pf_reg;
    lpcu_pkg::data_t    s2_c_reg;
    lpcu_pkg::data_t    s2_po_reg;
    lpcu_pkg::data_t    s3_g_reg [3];
    logic signed [17:0] s3_sum3_reg;
    lpcu_pkg::data_t    s3_c_reg;
    lpcu_pkg::data_t    s3_po_reg;
    lpcu_pkg::act_t     s4_cg_reg;
    lpcu_pkg::act_t     s4_ig_reg;
    lpcu_pkg::act_t     s4_fg_reg;
    logic signed [17:0] s4_sum3_reg;
    lpcu_pkg::data_t    s4_c_reg;
    lpcu_pkg::data_t    s4_po_reg;
    logic signed [32:0] s5_pf_reg;
    logic signed [33:0] s5_pc_reg;
    logic signed [17:0] s5_sum3_reg;
    lpcu_pkg::data_t    s5_po_reg;
    lpcu_pkg::data_t    s6_cout_reg;
    logic signed [17:0] s6_sum3_reg;
    lpcu_pkg::data_t    s6_po_reg;
    logic signed [31:0] s7_pp_reg;
    lpcu_pkg::act_t     s7_tc_reg;
    lpcu_pkg::data_t    s7_cout_reg;
    logic signed [17:0] s7_sum3_reg;
    lpcu_pkg::data_t    s8_g3_reg;
    lpcu_pkg::act_t     s8_tc_reg;
    lpcu_pkg::data_t    s8_cout_reg;
    lpcu_pkg::act_t     s9_og_reg;
    lpcu_pkg::act_t     s9_tc_reg;
    lpcu_pkg::data_t    s9_cout_reg;
    logic signed [33:0] s10_ph_reg;
    lpcu_pkg::data_t    s10_cout_reg;
    lpcu_pkg::data_t    s11_cout_reg;
    lpcu_pkg::data_t    s11_hid_reg;

    // The whole pipeline advances unless a result waits at the output.
    assign adv      = ~vld_reg[NS-1] | out_ready;
    assign in_ready = adv;
    assign in_acc   = in_valid & in_ready;
    assign cmp_acc  = in_acc & (func == lpcu_pkg::FUNC_COMPUTE);
    assign load_acc = in_acc & (func == lpcu_pkg::FUNC_LOAD);

    assign idx_ext = RED_W'(unit_mod(unit));
    assign idx     = idx_ext[IDX_W-1:0];

    // Weight tables; a load writes at acceptance, a compute reads at acceptance.
    lpcu_ram #(
        .WIDTH (lpcu_pkg::BIAS_W),
        .DEPTH (UNITS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (idx),
        .wdata ({gate_x_3, gate_x_2, gate_x_1, gate_x_0}),
        .re    (cmp_acc),
        .raddr (idx),
        .rdata (bias_rd)
    );

    lpcu_ram #(
        .WIDTH (lpcu_pkg::PEEP_W),
        .DEPTH (UNITS)
    ) u_peep_ram (
        .clk   (clk),
        .we    (load_acc),
        .waddr (idx),
        .wdata ({gate_h_2, gate_h_1, gate_h_0}),
        .re    (cmp_acc),
        .raddr (idx),
        .rdata (peep_rd)
    );

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], cmp_acc};
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Capture the request.
            s1_x_reg[0] <= gate_x_0;
            s1_x_reg[1] <= gate_x_1;
            s1_x_reg[2] <= gate_x_2;
            s1_x_reg[3] <= gate_x_3;
            s1_h_reg[0] <= gate_h_0;
            s1_h_reg[1] <= gate_h_1;
            s1_h_reg[2] <= gate_h_2;
            s1_h_reg[3] <= gate_h_3;
            s1_c_reg    <= cell_in;

            // Gate sums with bias, and the input and forget peephole products.
            for (int k = 0; k < 4; k++)
            begin
                s2_sum_reg[k] <= 18'(s1_x_reg[k]) + 18'(s1_h_reg[k])
                               + 18'($signed(bias_rd[16*k +: 16]));
            end
            s2_pi_reg <= 32'(s1_c_reg) * 32'($signed(peep_rd[15:0]));
            s2_pf_reg <= 32'(s1_c_reg) * 32'($signed(peep_rd[31:16]));
            s2_c_reg  <= s1_c_reg;
            s2_po_reg <= $signed(peep_rd[47:32]);

            // Add the peephole terms and saturate.
            s3_g_reg[0] <= sat16(40'(s2_sum_reg[0]));
            s3_g_reg[1] <= sat16(40'(s2_sum_reg[1]) + rnd(40'(s2_pi_reg)));
            s3_g_reg[2] <= sat16(40'(s2_sum_reg[2]) + rnd(40'(s2_pf_reg)));
            s3_sum3_reg <= s2_sum_reg[3];
            s3_c_reg    <= s2_c_reg;
            s3_po_reg   <= s2_po_reg;

            // Activations of gates 0, input and forget.
            s4_cg_reg   <= tanh_fx(17'(s3_g_reg[0]));
            s4_ig_reg   <= sigm(18'(s3_g_reg[1]));
            s4_fg_reg   <= sigm(18'(s3_g_reg[2]));
            s4_sum3_reg <= s3_sum3_reg;
            s4_c_reg    <= s3_c_reg;
            s4_po_reg   <= s3_po_reg;

            // Forget and input products.
            s5_pf_reg   <= 33'(s4_fg_reg) * 33'(s4_c_reg);
            s5_pc_reg   <= 34'(s4_ig_reg) * 34'(s4_cg_reg);
            s5_sum3_reg <= s4_sum3_reg;
            s5_po_reg   <= s4_po_reg;

            // New cell value.
            s6_cout_reg <= sat16(rnd(40'(s5_pf_reg) + 40'(s5_pc_reg)));
            s6_sum3_reg <= s5_sum3_reg;
            s6_po_reg   <= s5_po_reg;

            // Output peephole product and tanh of the new cell.
            s7_pp_reg   <= 32'(s6_cout_reg) * 32'(s6_po_reg);
            s7_tc_reg   <= tanh_fx(17'(s6_cout_reg));
            s7_cout_reg <= s6_cout_reg;
            s7_sum3_reg <= s6_sum3_reg;

            // Output gate pre-activation.
            s8_g3_reg   <= sat16(40'(s7_sum3_reg) + rnd(40'(s7_pp_reg)));
            s8_tc_reg   <= s7_tc_reg;
            s8_cout_reg <= s7_cout_reg;

            // Output gate activation.
            s9_og_reg   <= sigm(18'(s8_g3_reg));
            s9_tc_reg   <= s8_tc_reg;
            s9_cout_reg <= s8_cout_reg;

            // Hidden product.
            s10_ph_reg   <= 34'(s9_og_reg) * 34'(s9_tc_reg);
            s10_cout_reg <= s9_cout_reg;

            // Output register.
            s11_hid_reg  <= sat16(rnd(40'(s10_ph_reg)));
            s11_cout_reg <= s10_cout_reg;
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign cell_out   = s11_cout_reg;
    assign hidden_out = s11_hid_reg;

    `include "lstm_peephole_cell_update_macros.svh"

    // A stalled pipeline keeps every valid bit.
    `LPCU_ASSERT_NXT(a_stall_holds, !adv, $stable(vld_reg))
    // A compute request enters the first stage.
    `LPCU_ASSERT_NXT(a_cmp_enters, cmp_acc, vld_reg[0])
    // A load request leaves a bubble in the first stage.
    `LPCU_ASSERT_NXT(a_load_bubble, load_acc, !vld_reg[0])
    // A result only appears when the stage before held one.
    `LPCU_ASSERT_IMP(a_out_source, $rose(out_valid), $past(vld_reg[NS-2]))

endmodule
